// ===== rtl/core/t88rg_pkg.sv =====
// t88rg_pkg: shared types, codes and constants for the taus88 generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package t88rg_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned KindW = 3;
  localparam int unsigned FracW = 23;
  localparam int unsigned LcgRounds = 3;

  localparam logic [WordW-1:0] LCG_MUL   = 32'd214013;
  localparam logic [WordW-1:0] LCG_ADD   = 32'd2531011;
  localparam logic [WordW-1:0] MIN_ONE   = 32'h0010_0000;
  localparam logic [WordW-1:0] MIN_TWO   = 32'h0000_1000;
  localparam logic [WordW-1:0] MIN_THREE = 32'h0000_0010;

  typedef enum logic [KindW-1:0] {
    KIND_DRAW     = 3'd0,
    KIND_PEEK     = 3'd1,
    KIND_ROLLBACK = 3'd2,
    KIND_SEED     = 3'd3,
    KIND_LOAD     = 3'd4
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEED
  } state_t;

  typedef struct packed {
    logic             start;
    logic [WordW-1:0] seed;
  } lcg_ctl_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [WordW-1:0] result;
  } lcg_sts_t;

  function automatic logic [WordW-1:0] lcg_next(input logic [WordW-1:0] x);
    logic [WordW-1:0] prod;
    prod = x * LCG_MUL;
    return prod + LCG_ADD;
  endfunction

  // LCG of seed zero, three rounds: state after reset
  localparam logic [WordW-1:0] RESET_X = lcg_next(lcg_next(lcg_next('0)));

endpackage

// ===== rtl/core/taus88_random_generator_unit.sv =====
// taus88_random_generator_unit: taus88 generator with saved state and rollback.
// Depends on t88rg_pkg, t88rg_step and t88rg_lcg_unit.
//
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   in_kind, in_seed_value, in_seed_one..three
// out      output     out_valid / out_ready out_value, out_fraction
//
// Draw, peek, rollback and raw load: one item per cycle while in_ready is high.
// Seed from value: three LCG rounds in the iterative LCG unit t88rg_lcg_unit.
// Reset leaves the state as seeded with zero, with no warm-up.
// A result sits in an output register; the next item is taken while it drains.
// in_ready is low while seeding and while a result is stalled.
`timescale 1ns / 1ps

module taus88_random_generator_unit
  import t88rg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [KindW-1:0] in_kind,
  input  logic [WordW-1:0] in_seed_value,
  input  logic [WordW-1:0] in_seed_one,
  input  logic [WordW-1:0] in_seed_two,
  input  logic [WordW-1:0] in_seed_three,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WordW-1:0] out_value,
  output logic [FracW-1:0] out_fraction
);

  state_t           state_r, state_nxt;
  logic [WordW-1:0] comp_one_r, comp_two_r, comp_three_r;
  logic [WordW-1:0] saved_one_r, saved_two_r, saved_three_r;
  logic             out_valid_r;
  logic [WordW-1:0] out_value_r;

  logic [WordW-1:0] src_one, src_two, src_three;
  logic [WordW-1:0] n_one, n_two, n_three, word;
  logic             in_fire;
  kind_t            kind;
  lcg_ctl_t         lcg_ctl;
  lcg_sts_t         lcg_sts;

  assign kind     = kind_t'(in_kind);
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  // peek steps the saved copy, everything else the live one
  assign src_one   = (kind == KIND_PEEK) ? saved_one_r : comp_one_r;
  assign src_two   = (kind == KIND_PEEK) ? saved_two_r : comp_two_r;
  assign src_three = (kind == KIND_PEEK) ? saved_three_r : comp_three_r;

  t88rg_step u_step (
    .s_one   (src_one),
    .s_two   (src_two),
    .s_three (src_three),
    .n_one   (n_one),
    .n_two   (n_two),
    .n_three (n_three),
    .word    (word)
  );

  t88rg_lcg_unit u_lcg (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (lcg_ctl),
    .sts   (lcg_sts)
  );

  always_comb begin
    state_nxt     = state_r;
    lcg_ctl.start = 1'b0;
    lcg_ctl.seed  = in_seed_value;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && kind == KIND_SEED) begin
          lcg_ctl.start = 1'b1;
          state_nxt     = ST_SEED;
        end
      end
      ST_SEED: begin
        if (lcg_sts.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      comp_one_r    <= RESET_X | MIN_ONE;
      comp_two_r    <= RESET_X | MIN_TWO;
      comp_three_r  <= RESET_X | MIN_THREE;
      saved_one_r   <= RESET_X | MIN_ONE;
      saved_two_r   <= RESET_X | MIN_TWO;
      saved_three_r <= RESET_X | MIN_THREE;
    end else begin
      state_r <= state_nxt;
      if (in_fire && (kind == KIND_DRAW || kind == KIND_PEEK)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_SEED && lcg_sts.done) begin
        comp_one_r    <= lcg_sts.result | MIN_ONE;
        comp_two_r    <= lcg_sts.result | MIN_TWO;
        comp_three_r  <= lcg_sts.result | MIN_THREE;
        saved_one_r   <= lcg_sts.result | MIN_ONE;
        saved_two_r   <= lcg_sts.result | MIN_TWO;
        saved_three_r <= lcg_sts.result | MIN_THREE;
      end
      if (in_fire) begin
        unique case (kind)
          KIND_DRAW: begin
            saved_one_r   <= comp_one_r;
            saved_two_r   <= comp_two_r;
            saved_three_r <= comp_three_r;
            comp_one_r    <= n_one;
            comp_two_r    <= n_two;
            comp_three_r  <= n_three;
            out_value_r   <= word;
          end
          KIND_PEEK: begin
            out_value_r <= word;
          end
          KIND_ROLLBACK: begin
            comp_one_r   <= saved_one_r;
            comp_two_r   <= saved_two_r;
            comp_three_r <= saved_three_r;
          end
          KIND_LOAD: begin
            comp_one_r    <= in_seed_one;
            comp_two_r    <= in_seed_two;
            comp_three_r  <= in_seed_three;
            saved_one_r   <= in_seed_one;
            saved_two_r   <= in_seed_two;
            saved_three_r <= in_seed_three;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_fraction = out_value_r[FracW-1:0];

  a_no_accept_while_seeding: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEED |-> !in_ready)
    else $error("item accepted during seeding");

  a_lcg_busy_in_seed: assert property (@(posedge clk) disable iff (!rst_n)
    (lcg_sts.busy || lcg_sts.done) |-> state_r == ST_SEED)
    else $error("lcg unit active outside seeding");

  a_result_from_draw: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_fire && (kind == KIND_DRAW || kind == KIND_PEEK)))
    else $error("result without draw or peek");

  a_rollback_restores: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && kind == KIND_ROLLBACK) |=>
      (comp_one_r == saved_one_r && comp_two_r == saved_two_r &&
       comp_three_r == saved_three_r))
    else $error("rollback did not restore saved state");

endmodule

// ===== rtl/core/t88rg_lcg_unit.sv =====
// t88rg_lcg_unit: iterative LCG x*214013+2531011, one round per cycle.
// Depends on t88rg_pkg.
`timescale 1ns / 1ps

module t88rg_lcg_unit
  import t88rg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  lcg_ctl_t ctl,
  output lcg_sts_t sts
);

  localparam int unsigned CntW = $clog2(LcgRounds + 1);

  logic [WordW-1:0] x_r, x_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [WordW-1:0] prod;

  assign prod = x_r * LCG_MUL;

  always_comb begin
    x_nxt    = x_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      x_nxt    = ctl.seed;
      cnt_nxt  = CntW'(LcgRounds);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt    = prod + LCG_ADD;
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != CntW'(1));
      done_nxt = (cnt_r == CntW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r <= x_nxt;
  end

  assign sts.busy   = busy_r;
  assign sts.done   = done_r;
  assign sts.result = x_r;

endmodule

// ===== rtl/core/t88rg_step.sv =====
// t88rg_step: one taus88 step of all three components and their XOR.
// Depends on t88rg_pkg.
`timescale 1ns / 1ps

module t88rg_step
  import t88rg_pkg::*;
(
  input  logic [WordW-1:0] s_one,
  input  logic [WordW-1:0] s_two,
  input  logic [WordW-1:0] s_three,
  output logic [WordW-1:0] n_one,
  output logic [WordW-1:0] n_two,
  output logic [WordW-1:0] n_three,
  output logic [WordW-1:0] word
);

  logic [WordW-1:0] fb_one, fb_two, fb_three;

  assign fb_one   = ((s_one << 13) ^ s_one) >> 19;
  assign fb_two   = ((s_two << 2) ^ s_two) >> 25;
  assign fb_three = ((s_three << 3) ^ s_three) >> 11;

  assign n_one   = ((s_one & 32'hFFFF_FFFE) << 12) ^ fb_one;
  assign n_two   = ((s_two & 32'hFFFF_FFF8) << 4) ^ fb_two;
  assign n_three = ((s_three & 32'hFFFF_FFF0) << 17) ^ fb_three;
  assign word    = n_one ^ n_two ^ n_three;

endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for taus88_random_generator_unit.
// Keeps its own model of the three components and the saved copy, predicts each
// draw and peek, and compares every result; depends on t88rg_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import t88rg_pkg::*;

  localparam logic [KindW-1:0] KIND_SPARE_A = 3'd5;
  localparam logic [KindW-1:0] KIND_SPARE_B = 3'd6;
  localparam logic [KindW-1:0] KIND_SPARE_C = 3'd7;
  localparam logic [WordW-1:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam int CycleLimit = 400000;

  typedef struct {
    logic [WordW-1:0] value;
    logic [FracW-1:0] fraction;
  } draw_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [KindW-1:0] in_kind;
  logic [WordW-1:0] in_seed_value;
  logic [WordW-1:0] in_seed_one;
  logic [WordW-1:0] in_seed_two;
  logic [WordW-1:0] in_seed_three;
  logic             out_valid;
  logic             out_ready;
  logic [WordW-1:0] out_value;
  logic [FracW-1:0] out_fraction;

  logic [WordW-1:0] live_c[3];
  logic [WordW-1:0] saved_c[3];
  draw_t            draw_q[$];
  draw_t            got_draw;
  int               err_cnt = 0;
  int               cycle_cnt = 0;
  int               stall_pct = 0;
  int               gap_max = 0;
  int               burst_left = 0;
  bit               hold_req = 1'b0;
  int               hold_len = 0;
  int               hold_cnt = 0;

  taus88_random_generator_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_seed_value(in_seed_value),
    .in_seed_one  (in_seed_one),
    .in_seed_two  (in_seed_two),
    .in_seed_three(in_seed_three),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_fraction (out_fraction)
  );

  always #4ns clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("taus88_random_generator_unit regression: fail");
      $finish;
    end
  end

  // taus88 component recurrences
  function automatic logic [WordW-1:0] taus_next_one(input logic [WordW-1:0] s);
    logic [WordW-1:0] fb;
    logic [WordW-1:0] hi;
    fb = (s << 13) ^ s;
    fb = fb >> 19;
    hi = (s & 32'hFFFF_FFFE) << 12;
    return hi ^ fb;
  endfunction

  function automatic logic [WordW-1:0] taus_next_two(input logic [WordW-1:0] s);
    logic [WordW-1:0] fb;
    logic [WordW-1:0] hi;
    fb = (s << 2) ^ s;
    fb = fb >> 25;
    hi = (s & 32'hFFFF_FFF8) << 4;
    return hi ^ fb;
  endfunction

  function automatic logic [WordW-1:0] taus_next_three(input logic [WordW-1:0] s);
    logic [WordW-1:0] fb;
    logic [WordW-1:0] hi;
    fb = (s << 3) ^ s;
    fb = fb >> 11;
    hi = (s & 32'hFFFF_FFF0) << 17;
    return hi ^ fb;
  endfunction

  function automatic logic [WordW-1:0] lcg_scramble(input logic [WordW-1:0] v);
    logic [WordW-1:0] x;
    x = v;
    for (int i = 0; i < 3; i++) begin
      x = x * LCG_MUL;
      x = x + LCG_ADD;
    end
    return x;
  endfunction

  task automatic load_components(input logic [WordW-1:0] a, input logic [WordW-1:0] b,
                                 input logic [WordW-1:0] c);
    live_c[0] = a;
    live_c[1] = b;
    live_c[2] = c;
    saved_c = live_c;
  endtask

  task automatic seed_components(input logic [WordW-1:0] v);
    logic [WordW-1:0] x;
    x = lcg_scramble(v);
    load_components(x | 32'h0010_0000, x | 32'h0000_1000, x | 32'h0000_0010);
  endtask

  task automatic push_draw(input logic [WordW-1:0] w);
    draw_t d;
    d.value = w;
    d.fraction = w[FracW-1:0];
    draw_q.push_back(d);
  endtask

  task automatic apply_item(input logic [KindW-1:0] k, input logic [WordW-1:0] sv,
                            input logic [WordW-1:0] s1, input logic [WordW-1:0] s2,
                            input logic [WordW-1:0] s3);
    case (k)
      KIND_DRAW: begin
        saved_c = live_c;
        live_c[0] = taus_next_one(live_c[0]);
        live_c[1] = taus_next_two(live_c[1]);
        live_c[2] = taus_next_three(live_c[2]);
        push_draw(live_c[0] ^ live_c[1] ^ live_c[2]);
      end
      KIND_PEEK: begin
        push_draw(taus_next_one(saved_c[0]) ^ taus_next_two(saved_c[1]) ^
                  taus_next_three(saved_c[2]));
      end
      KIND_ROLLBACK: live_c = saved_c;
      KIND_SEED: seed_components(sv);
      KIND_LOAD: load_components(s1, s2, s3);
      default: ;
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [KindW-1:0] k, input logic [WordW-1:0] sv,
                           input logic [WordW-1:0] s1, input logic [WordW-1:0] s2,
                           input logic [WordW-1:0] s3);
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid = 1'b1;
    in_kind = k;
    in_seed_value = sv;
    in_seed_one = s1;
    in_seed_two = s2;
    in_seed_three = s3;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_item(k, sv, s1, s2, s3);
    @(negedge clk);
  endtask

  task automatic send_kind(input logic [KindW-1:0] k);
    send_item(k, $urandom, $urandom, $urandom, $urandom);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (draw_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result value %h fraction %h", $time, out_value,
                 out_fraction);
      end else begin
        got_draw = draw_q.pop_front();
        if (out_value !== got_draw.value) begin
          err_cnt++;
          $display("%0t: value mismatch exp %h got %h", $time, got_draw.value, out_value);
        end
        if (out_fraction !== got_draw.fraction) begin
          err_cnt++;
          $display("%0t: fraction mismatch exp %h got %h", $time, got_draw.fraction,
                   out_fraction);
        end
      end
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = hold_len;
      end
      if (hold_cnt > 0) begin
        out_ready = 1'b0;
        hold_cnt--;
      end else begin
        out_ready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic test_after_reset();
    send_kind(KIND_PEEK);
    send_kind(KIND_DRAW);
    send_kind(KIND_PEEK);
    send_kind(KIND_DRAW);
    send_kind(KIND_ROLLBACK);
    send_kind(KIND_DRAW);
  endtask

  task automatic test_seeding();
    send_item(KIND_SEED, '0, '0, '0, '0);
    send_kind(KIND_DRAW);
    send_item(KIND_SEED, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send_kind(KIND_PEEK);
    send_kind(KIND_DRAW);
    send_kind(KIND_DRAW);
    send_kind(KIND_ROLLBACK);
    send_kind(KIND_ROLLBACK);
    send_kind(KIND_PEEK);
  endtask

  task automatic test_raw_load();
    send_item(KIND_LOAD, ALL_ONES, '0, '0, '0);
    send_kind(KIND_DRAW);
    send_item(KIND_LOAD, '0, ALL_ONES, ALL_ONES, ALL_ONES);
    send_kind(KIND_DRAW);
    send_kind(KIND_PEEK);
    send_item(KIND_LOAD, $urandom, 32'h0000_0001, 32'h0000_0007, 32'h8000_0000);
    send_kind(KIND_DRAW);
  endtask

  task automatic test_unused_kinds();
    send_kind(KIND_SPARE_A);
    send_kind(KIND_SPARE_B);
    send_kind(KIND_SPARE_C);
    send_kind(KIND_DRAW);
  endtask

  // long receiver hold-off while draws and peeks keep coming, so the input stalls
  task automatic test_output_hold();
    hold_len = 300;
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) send_kind((i % 4 == 3) ? KIND_PEEK : KIND_DRAW);
  endtask

  function automatic logic [WordW-1:0] rand_component();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom;
    if (r < 90) return $urandom_range(0, 255);
    return 32'h1 << $urandom_range(0, 31);
  endfunction

  task automatic test_random_traffic(input int n_items, input int stall, input int gap);
    int r;
    stall_pct = stall;
    gap_max = gap;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) send_kind(KIND_DRAW);
      else if (r < 70) send_kind(KIND_PEEK);
      else if (r < 80) send_kind(KIND_ROLLBACK);
      else if (r < 87) send_kind(KIND_SEED);
      else if (r < 94) send_item(KIND_LOAD, $urandom, rand_component(), rand_component(),
                                 rand_component());
      else if (r < 96) send_kind(KIND_SPARE_A);
      else if (r < 98) send_kind(KIND_SPARE_B);
      else send_kind(KIND_SPARE_C);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_DRAW;
    in_seed_value = '0;
    in_seed_one = '0;
    in_seed_two = '0;
    in_seed_three = '0;
    seed_components('0);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_after_reset();
    test_seeding();
    test_raw_load();
    test_unused_kinds();
    test_output_hold();
    test_random_traffic(350, 0, 0);
    test_random_traffic(350, 25, 4);
    test_random_traffic(300, 60, 8);
    test_random_traffic(300, 10, 2);

    in_valid = 1'b0;
    stall_pct = 20;
    while (draw_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("taus88_random_generator_unit regression: pass");
    end else begin
      $display("taus88_random_generator_unit regression: fail");
    end
    $finish;
  end

endmodule
